// ----- src/lobm_pkg.sv -----
package lobm_pkg;

    localparam int MAX_ORDERS = 32;
    localparam int SLOT_W     = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int AVAIL_W    = 32 + SLOT_W + 1;
    localparam int Q_DEPTH    = 2;
    localparam int QP_W       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W       = $clog2(Q_DEPTH + 1);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_ORDERS - 1);

    localparam logic       SIDE_BUY    = 1'b0;
    localparam logic       KIND_MARKET = 1'b1;
    localparam logic       REC_TRADE   = 1'b0;
    localparam logic       REC_REPORT  = 1'b1;
    localparam logic [1:0] TIF_GTC     = 2'd0;
    localparam logic [1:0] TIF_FOK     = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_MODIFY = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        RJ_NONE    = 3'd0,
        RJ_UNKNOWN = 3'd1,
        RJ_DUP     = 3'd2,
        RJ_QTY     = 3'd3,
        RJ_PRICE   = 3'd4,
        RJ_LIQ     = 3'd5,
        RJ_FOK     = 3'd6,
        RJ_FULL    = 3'd7
    } t_rej;

    typedef enum logic [1:0] {
        FS_NEW       = 2'd0,
        FS_PARTIAL   = 2'd1,
        FS_FILLED    = 2'd2,
        FS_CANCELLED = 2'd3
    } t_fstate;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_ADD_CHK,
        S_LIQ,
        S_LIQ_CHK,
        S_BEST,
        S_TRADE,
        S_FINISH,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic [1:0]         operation;
        logic [31:0]        order_id;
        logic [15:0]        trader;
        logic               side;
        logic               order_type;
        logic signed [31:0] price;
        logic [31:0]        quantity;
        logic [1:0]         tif;
    } t_in_item;

    typedef struct packed {
        logic               result_last;
        logic               record_kind;
        logic               accepted;
        logic [2:0]         reject_code;
        logic [1:0]         final_state;
        logic [31:0]        filled_qty;
        logic [31:0]        remaining_qty;
        logic [31:0]        contra_order_id;
        logic [15:0]        contra_trader_id;
        logic signed [31:0] fill_price;
        logic [31:0]        fill_qty;
        logic               priority_lost;
    } t_out_item;

    // classified word between front and back
    typedef struct packed {
        t_op                op;
        logic [31:0]        order_id;
        logic [15:0]        trader;
        logic               side;
        logic               kind;
        logic signed [31:0] price;
        logic [31:0]        quantity;
        logic [1:0]         tif;
        logic               id_zero;
        logic               qty_zero;
        logic               price_bad;
    } t_q_item;

    typedef struct packed {
        logic [31:0]        order_id;
        logic [15:0]        trader;
        logic               side;
        logic               kind;
        logic signed [31:0] price;
        logic [31:0]        remaining;
        logic [1:0]         tif;
        logic [15:0]        arrival;
    } t_slot;

    function automatic logic f_crosses(input logic side, input logic market,
                                       input logic signed [31:0] lim,
                                       input logic signed [31:0] p);
        logic res;
        if (market) begin
            res = 1'b1;
        end else if (side == SIDE_BUY) begin
            res = (p <= lim);
        end else begin
            res = (p >= lim);
        end
        return res;
    endfunction

    // true if candidate beats the current best: price first, then age
    function automatic logic f_better(input logic side,
                                      input logic signed [31:0] p_i,
                                      input logic [15:0] age_i,
                                      input logic signed [31:0] p_b,
                                      input logic [15:0] age_b);
        logic res;
        if (p_i != p_b) begin
            res = (side == SIDE_BUY) ? (p_i < p_b) : (p_i > p_b);
        end else begin
            res = (age_i > age_b);
        end
        return res;
    endfunction

endpackage

// ----- src/lobm_ifs.sv -----
interface lobm_in_if;
    logic                 valid;
    logic                 ready;
    lobm_pkg::t_in_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lobm_out_if;
    logic                 valid;
    logic                 ready;
    lobm_pkg::t_out_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/lobm_front.sv -----
module lobm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lobm_in_if.sink            i_in,
    output logic               o_q_valid,
    output lobm_pkg::t_q_item  o_q_item,
    input  logic               i_q_ready
);

    lobm_pkg::t_q_item                r_q [lobm_pkg::Q_DEPTH];
    logic [lobm_pkg::QP_W-1:0]        r_wp;
    logic [lobm_pkg::QP_W-1:0]        r_rp;
    logic [lobm_pkg::QC_W-1:0]        r_cnt;
    lobm_pkg::t_q_item                w_item;
    logic                             w_push;
    logic                             w_pop;

    // classify the incoming word
    always_comb begin
        w_item.op        = lobm_pkg::t_op'(i_in.data.operation);
        w_item.order_id  = i_in.data.order_id;
        w_item.trader    = i_in.data.trader;
        w_item.side      = i_in.data.side;
        w_item.kind      = i_in.data.order_type;
        w_item.price     = i_in.data.price;
        w_item.quantity  = i_in.data.quantity;
        w_item.tif       = i_in.data.tif;
        w_item.id_zero   = (i_in.data.order_id == 32'd0);
        w_item.qty_zero  = (i_in.data.quantity == 32'd0);
        w_item.price_bad = (i_in.data.price <= 32'sd0);
    end

    assign i_in.ready = (r_cnt != lobm_pkg::QC_W'(lobm_pkg::Q_DEPTH));
    // drop no-op words at the door
    assign w_push     = i_in.valid && i_in.ready && (w_item.op != lobm_pkg::OP_NOP);
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_q[r_rp];
    assign w_pop      = o_q_valid && i_q_ready;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == lobm_pkg::QP_W'(lobm_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == lobm_pkg::QP_W'(lobm_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // hold queue entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= lobm_pkg::QC_W'(lobm_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- src/lobm_back.sv -----
module lobm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  lobm_pkg::t_q_item  i_q_item,
    output logic               o_q_ready,
    lobm_out_if.source         o_out
);

    localparam int SW = lobm_pkg::SLOT_W;
    localparam int N  = lobm_pkg::MAX_ORDERS;

    lobm_pkg::t_state           r_state;
    lobm_pkg::t_state           n_state;
    lobm_pkg::t_q_item          r_item;

    // slot store and flags
    lobm_pkg::t_slot            r_mem [N];
    logic                       r_valid [N];
    logic [15:0]                r_arrival;

    // scan pipeline
    logic [SW-1:0]              r_scan_idx;
    logic                       r_iss;
    logic                       r_p_vld;
    logic [SW-1:0]              r_p_idx;
    logic                       r_p_sv;
    lobm_pkg::t_slot            r_rd;
    logic                       w_done;
    logic                       w_scan_start;

    // scan results
    logic                       r_found;
    logic [SW-1:0]              r_fidx;
    lobm_pkg::t_slot            r_frec;
    logic                       r_any;
    logic [lobm_pkg::AVAIL_W-1:0] r_avail;
    logic                       r_bfound;
    logic [SW-1:0]              r_bidx;
    lobm_pkg::t_slot            r_brec;
    logic                       r_free_found;
    logic [SW-1:0]              r_free_idx;

    // report fields
    logic [31:0]                r_rem;
    logic                       r_plost;
    logic                       r_acc;
    lobm_pkg::t_rej             r_code;
    lobm_pkg::t_fstate          r_fst;
    logic [31:0]                r_filled;
    logic [31:0]                r_remout;
    logic [15:0]                r_ctr;

    // output register
    logic                       r_out_vld;
    lobm_pkg::t_out_item        r_out;
    logic                       w_out_free;
    logic                       w_emit;
    lobm_pkg::t_out_item        w_word;

    // decode helpers
    logic                       w_market;
    logic                       w_amend;
    logic                       w_add_rej;
    lobm_pkg::t_rej             w_add_code;
    logic                       w_liq_rej;
    logic                       w_contra;
    logic                       w_cand;
    logic [15:0]                w_age_i;
    logic [15:0]                w_age_b;
    logic [31:0]                w_t;
    logic [31:0]                w_rem_next;
    logic [31:0]                w_slot_next;
    logic                       w_rest;
    logic                       w_wr;
    logic [SW-1:0]              w_wr_idx;
    lobm_pkg::t_slot            w_wr_rec;
    logic                       w_clr;
    logic [SW-1:0]              w_clr_idx;
    logic                       w_set;

    assign w_market   = (r_item.kind == lobm_pkg::KIND_MARKET);
    assign w_done     = r_p_vld && (r_p_idx == lobm_pkg::LAST_SLOT);
    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_amend    = (r_item.price == r_frec.price) && (r_item.quantity <= r_frec.remaining);
    assign w_contra   = r_p_vld && r_p_sv && (r_rd.side != r_item.side);
    assign w_cand     = w_contra &&
                        lobm_pkg::f_crosses(r_item.side, w_market, r_item.price, r_rd.price);
    assign w_age_i    = r_arrival - r_rd.arrival;
    assign w_age_b    = r_arrival - r_brec.arrival;
    assign w_t        = (r_rem < r_brec.remaining) ? r_rem : r_brec.remaining;
    assign w_rem_next = r_rem - w_t;
    assign w_slot_next = r_brec.remaining - w_t;
    assign w_rest     = !w_market && (r_item.tif == lobm_pkg::TIF_GTC) && (r_rem != 32'd0);
    assign w_liq_rej  = (w_market && !r_any) ||
                        ((r_item.tif == lobm_pkg::TIF_FOK) &&
                         (r_avail < lobm_pkg::AVAIL_W'(r_item.quantity)));
    assign o_q_ready  = (r_state == lobm_pkg::S_IDLE);

    // rank add checks
    always_comb begin
        w_add_rej  = 1'b1;
        w_add_code = lobm_pkg::RJ_NONE;
        if (r_item.id_zero) begin
            w_add_code = lobm_pkg::RJ_UNKNOWN;
        end else if (r_found && !r_plost) begin
            w_add_code = lobm_pkg::RJ_DUP;
        end else if (r_item.qty_zero) begin
            w_add_code = lobm_pkg::RJ_QTY;
        end else if (!w_market && r_item.price_bad) begin
            w_add_code = lobm_pkg::RJ_PRICE;
        end else begin
            w_add_rej = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lobm_pkg::S_IDLE: begin
                if (i_q_valid) n_state = lobm_pkg::S_LOOKUP;
            end
            lobm_pkg::S_LOOKUP: begin
                if (w_done) n_state = lobm_pkg::S_DECIDE;
            end
            lobm_pkg::S_DECIDE: begin
                case (r_item.op)
                    lobm_pkg::OP_CANCEL: n_state = lobm_pkg::S_REPORT;
                    lobm_pkg::OP_MODIFY: begin
                        if (!r_found || r_item.qty_zero || r_item.price_bad || w_amend)
                            n_state = lobm_pkg::S_REPORT;
                        else
                            n_state = lobm_pkg::S_ADD_CHK;
                    end
                    default: n_state = lobm_pkg::S_ADD_CHK;
                endcase
            end
            lobm_pkg::S_ADD_CHK: begin
                if (w_add_rej)
                    n_state = lobm_pkg::S_REPORT;
                else if (w_market || (r_item.tif == lobm_pkg::TIF_FOK))
                    n_state = lobm_pkg::S_LIQ;
                else
                    n_state = lobm_pkg::S_BEST;
            end
            lobm_pkg::S_LIQ: begin
                if (w_done) n_state = lobm_pkg::S_LIQ_CHK;
            end
            lobm_pkg::S_LIQ_CHK: begin
                n_state = w_liq_rej ? lobm_pkg::S_REPORT : lobm_pkg::S_BEST;
            end
            lobm_pkg::S_BEST: begin
                // the last slot of the pass counts as a candidate too
                if (w_done)
                    n_state = (r_bfound || w_cand) ? lobm_pkg::S_TRADE : lobm_pkg::S_FINISH;
            end
            lobm_pkg::S_TRADE: begin
                if (w_out_free)
                    n_state = (w_rem_next == 32'd0) ? lobm_pkg::S_FINISH : lobm_pkg::S_BEST;
            end
            lobm_pkg::S_FINISH: n_state = lobm_pkg::S_REPORT;
            lobm_pkg::S_REPORT: begin
                if (w_out_free) n_state = lobm_pkg::S_IDLE;
            end
            default: n_state = lobm_pkg::S_IDLE;
        endcase
    end

    assign w_scan_start = (n_state != r_state) &&
                          ((n_state == lobm_pkg::S_LOOKUP) || (n_state == lobm_pkg::S_LIQ) ||
                           (n_state == lobm_pkg::S_BEST));

    // outputs: emitted word, slot writes and valid updates
    always_comb begin
        w_emit    = 1'b0;
        w_word    = '0;
        w_wr      = 1'b0;
        w_wr_idx  = r_fidx;
        w_wr_rec  = r_frec;
        w_clr     = 1'b0;
        w_clr_idx = r_fidx;
        w_set     = 1'b0;
        case (r_state)
            lobm_pkg::S_DECIDE: begin
                if (r_item.op == lobm_pkg::OP_CANCEL) begin
                    w_clr = r_found;
                end else if (r_item.op == lobm_pkg::OP_MODIFY && r_found &&
                             !r_item.qty_zero && !r_item.price_bad) begin
                    if (w_amend) begin
                        w_wr               = 1'b1;
                        w_wr_rec.remaining = r_item.quantity;
                    end else begin
                        w_clr = 1'b1;
                    end
                end
            end
            lobm_pkg::S_TRADE: begin
                w_emit                  = w_out_free;
                w_word.record_kind      = lobm_pkg::REC_TRADE;
                w_word.contra_order_id  = r_brec.order_id;
                w_word.contra_trader_id = r_brec.trader;
                w_word.fill_price       = r_brec.price;
                w_word.fill_qty         = w_t;
                w_wr_idx                = r_bidx;
                w_wr_rec                = r_brec;
                w_wr_rec.remaining      = w_slot_next;
                w_clr_idx               = r_bidx;
                w_wr                    = w_out_free && (w_slot_next != 32'd0);
                w_clr                   = w_out_free && (w_slot_next == 32'd0);
            end
            lobm_pkg::S_FINISH: begin
                w_wr_idx           = r_free_idx;
                w_wr_rec.order_id  = r_item.order_id;
                w_wr_rec.trader    = r_item.trader;
                w_wr_rec.side      = r_item.side;
                w_wr_rec.kind      = r_item.kind;
                w_wr_rec.price     = r_item.price;
                w_wr_rec.remaining = r_rem;
                w_wr_rec.tif       = r_item.tif;
                w_wr_rec.arrival   = r_arrival;
                w_wr               = w_rest && r_free_found;
                w_set              = w_rest && r_free_found;
            end
            lobm_pkg::S_REPORT: begin
                w_emit                  = w_out_free;
                w_word.result_last      = 1'b1;
                w_word.record_kind      = lobm_pkg::REC_REPORT;
                w_word.accepted         = r_acc;
                w_word.reject_code      = r_code;
                w_word.final_state      = r_fst;
                w_word.filled_qty       = r_filled;
                w_word.remaining_qty    = r_remout;
                w_word.contra_trader_id = r_ctr;
                w_word.priority_lost    = r_plost;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lobm_pkg::S_IDLE;
            r_arrival  <= '0;
            r_iss      <= 1'b0;
            r_p_vld    <= 1'b0;
            r_scan_idx <= '0;
            r_out_vld  <= 1'b0;
            for (int i = 0; i < N; i++) r_valid[i] <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_vld <= r_iss;
            if (w_scan_start) begin
                r_scan_idx <= '0;
                r_iss      <= 1'b1;
            end else if (r_iss) begin
                r_scan_idx <= r_scan_idx + 1'b1;
                if (r_scan_idx == lobm_pkg::LAST_SLOT) r_iss <= 1'b0;
            end
            if (w_clr) r_valid[w_clr_idx] <= 1'b0;
            if (w_set) begin
                r_valid[r_free_idx] <= 1'b1;
                r_arrival           <= r_arrival + 16'd1;
            end
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // slot memory with registered read; sample valid alongside
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[w_wr_idx] <= w_wr_rec;
        r_rd    <= r_mem[r_scan_idx];
        r_p_sv  <= r_valid[r_scan_idx];
        r_p_idx <= r_scan_idx;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_emit) r_out <= w_word;
        case (r_state)
            lobm_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    r_item   <= i_q_item;
                    r_plost  <= 1'b0;
                    r_acc    <= 1'b0;
                    r_code   <= lobm_pkg::RJ_NONE;
                    r_fst    <= lobm_pkg::FS_NEW;
                    r_filled <= '0;
                    r_remout <= '0;
                    r_ctr    <= '0;
                    r_found  <= 1'b0;
                end
            end
            lobm_pkg::S_LOOKUP: begin
                if (r_p_vld && r_p_sv && !r_found && (r_rd.order_id == r_item.order_id)) begin
                    r_found <= 1'b1;
                    r_fidx  <= r_p_idx;
                    r_frec  <= r_rd;
                end
            end
            lobm_pkg::S_DECIDE: begin
                if (r_item.op == lobm_pkg::OP_CANCEL) begin
                    if (r_found) begin
                        r_acc <= 1'b1;
                        r_fst <= lobm_pkg::FS_CANCELLED;
                        r_ctr <= r_frec.trader;
                    end else begin
                        r_code <= lobm_pkg::RJ_UNKNOWN;
                    end
                end else if (r_item.op == lobm_pkg::OP_MODIFY) begin
                    if (!r_found) begin
                        r_code <= lobm_pkg::RJ_UNKNOWN;
                    end else if (r_item.qty_zero) begin
                        r_code <= lobm_pkg::RJ_QTY;
                    end else if (r_item.price_bad) begin
                        r_code <= lobm_pkg::RJ_PRICE;
                    end else if (w_amend) begin
                        r_acc    <= 1'b1;
                        r_remout <= r_item.quantity;
                        r_fst    <= lobm_pkg::FS_PARTIAL;
                    end else begin
                        // re-add under stored attributes
                        r_plost       <= 1'b1;
                        r_item.trader <= r_frec.trader;
                        r_item.side   <= r_frec.side;
                        r_item.kind   <= r_frec.kind;
                        r_item.tif    <= r_frec.tif;
                    end
                end
            end
            lobm_pkg::S_ADD_CHK: begin
                if (w_add_rej) r_code <= w_add_code;
                r_rem <= r_item.quantity;
            end
            lobm_pkg::S_LIQ: begin
                if (w_contra) r_any <= 1'b1;
                if (w_cand) r_avail <= r_avail + lobm_pkg::AVAIL_W'(r_rd.remaining);
            end
            lobm_pkg::S_LIQ_CHK: begin
                if (w_market && !r_any) begin
                    r_code <= lobm_pkg::RJ_LIQ;
                end else if (w_liq_rej) begin
                    r_code <= lobm_pkg::RJ_FOK;
                end
            end
            lobm_pkg::S_BEST: begin
                if (w_cand && (!r_bfound ||
                    lobm_pkg::f_better(r_item.side, r_rd.price, w_age_i,
                                       r_brec.price, w_age_b))) begin
                    r_bfound <= 1'b1;
                    r_bidx   <= r_p_idx;
                    r_brec   <= r_rd;
                end
                if (r_p_vld && !r_p_sv && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_p_idx;
                end
            end
            lobm_pkg::S_TRADE: begin
                if (w_out_free) r_rem <= w_rem_next;
            end
            lobm_pkg::S_FINISH: begin
                r_acc    <= 1'b1;
                r_filled <= r_item.quantity - r_rem;
                if (w_rest) begin
                    if (r_free_found) begin
                        r_remout <= r_rem;
                        r_fst    <= (r_item.quantity != r_rem) ? lobm_pkg::FS_PARTIAL
                                                               : lobm_pkg::FS_NEW;
                    end else begin
                        r_code <= lobm_pkg::RJ_FULL;
                        r_fst  <= lobm_pkg::FS_CANCELLED;
                    end
                end else begin
                    r_fst <= (r_rem == 32'd0) ? lobm_pkg::FS_FILLED : lobm_pkg::FS_CANCELLED;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
        // clear accumulators at the start of each pass
        if (w_scan_start) begin
            r_any        <= 1'b0;
            r_avail      <= '0;
            r_bfound     <= 1'b0;
            r_free_found <= 1'b0;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    a_trade_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lobm_pkg::S_TRADE) |-> (r_rem != 32'd0 && r_brec.remaining != 32'd0))
        else $error("trade with nothing left to fill");

    a_rest_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_set |-> !r_valid[r_free_idx])
        else $error("resting into an occupied slot");

    a_pop_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lobm_pkg::S_IDLE && i_q_valid) |=> (r_state == lobm_pkg::S_LOOKUP && r_iss))
        else $error("lookup pass did not start");

    a_report_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lobm_pkg::S_REPORT && w_emit) |=> (r_state == lobm_pkg::S_IDLE && r_out_vld))
        else $error("report not closing the item");

endmodule

// ----- src/limit_order_book_matcher_core.sv -----
// A cancel, an amend or a rejected modify raises its report after one slot scan pass over the
// book; an add makes a lookup pass, a liquidity pass for a market or FOK order, and a best-price
// pass that is repeated after each fill that leaves quantity open. The matcher takes one word at
// a time, only when idle, and finishes it before it takes the next.
// A two-entry queue takes new words while the matcher works. Synchronous active-low reset
// empties the book, clears the arrival counter, the queue and the output register.
module limit_order_book_matcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lobm_in_if.sink     i_in,
    lobm_out_if.source  o_out
);

    logic               w_q_valid;
    logic               w_q_ready;
    lobm_pkg::t_q_item  w_q_item;

    lobm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_ready (w_q_ready)
    );

    lobm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_ready (w_q_ready),
        .o_out     (o_out)
    );

endmodule
